// ===== sv/mfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared widths, register indexes and control types of the mirrored FIR
// convolver.
// ----------------------------------------------------------------------------
package mfc_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int MAX_TAPS_DEF    = 15;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int REG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int RADIUS_W  = 3;
	localparam int TAP_W     = 4;
	localparam int COEF_WORDS = 4;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D     = 3'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	typedef struct packed {
		logic tap_vld;
		logic acc_clr;
	} mac_ctl_t;

endpackage

// ===== sv/mfc_in_if.sv =====
// ----------------------------------------------------------------------------
// mfc_in_if
// Input stream channel: one raw sample word with its frame end mark.
// ----------------------------------------------------------------------------
interface mfc_in_if;
	import mfc_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample_in;
	logic    frame_end;

	modport source (output valid, output sample_in, output frame_end, input ready);
	modport sink   (input valid, input sample_in, input frame_end, output ready);

endinterface

// ===== sv/mfc_out_if.sv =====
// ----------------------------------------------------------------------------
// mfc_out_if
// Output stream channel: one filtered word with run end and overflow flags.
// ----------------------------------------------------------------------------
interface mfc_out_if;
	import mfc_pkg::*;

	logic    valid;
	logic    ready;
	sample_t filtered;
	logic    run_end;
	logic    overflow;

	modport source (output valid, output filtered, output run_end, output overflow,
		input ready);
	modport sink   (input valid, input filtered, input run_end, input overflow,
		output ready);

endinterface

// ===== sv/mfc_ram.sv =====
// ----------------------------------------------------------------------------
// mfc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/mfc_mac.sv =====
// ----------------------------------------------------------------------------
// mfc_mac
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// ----------------------------------------------------------------------------
module mfc_mac #(
	parameter int MAX_TAPS = mfc_pkg::MAX_TAPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mfc_pkg::mac_ctl_t ctl,
	input  mfc_pkg::sample_t  sample,
	input  mfc_pkg::coef_t    coef,
	output logic              busy,
	output mfc_pkg::sample_t  result
);
	import mfc_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W:0]    rnd;
	logic signed [ACC_W:0]    shf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s2 <= ctl.tap_vld;
			if (ctl.acc_clr) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tap_vld) begin
			prod_s2 <= sample * coef;
		end
	end

	// Round to nearest with ties toward plus infinity, then saturate.
	always_comb begin
		rnd = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(16384);
		shf = rnd >>> 15;
		if (shf > $signed((ACC_W+1)'(32767))) begin
			result = 16'sh7fff;
		end else if (shf < -$signed((ACC_W+1)'(32768))) begin
			result = 16'sh8000;
		end else begin
			result = shf[SAMPLE_W-1:0];
		end
	end

	assign busy = vld_s2;

endmodule

// ===== sv/mirrored_fir_convolver_top.sv =====
// ----------------------------------------------------------------------------
// mirrored_fir_convolver_top
// Frame buffer with a mirrored-edge FIR filter on one shared MAC unit.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid / ready    | sample_in, frame_end
//   out_ch   | out | valid / ready    | filtered, run_end, overflow
//   cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// A sample word is taken whenever valid is high while the block is loading
// a frame. The word that ends a frame starts the filter pass: each output
// runs 2r+1 taps through the shared MAC, then waits in the drain state
// until the tap pipeline is empty, and input is held off until the pass ends.
// A stalled output register holds the pass; reset clears all control state
// and needs no clearing pass over the frame store.
// ----------------------------------------------------------------------------
module mirrored_fir_convolver_top #(
	parameter int MAX_SAMPLES = mfc_pkg::MAX_SAMPLES_DEF,
	parameter int MAX_TAPS    = mfc_pkg::MAX_TAPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mfc_in_if.sink                         in_ch,
	mfc_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfc_pkg::REG_W-1:0]      cfg_data
);
	import mfc_pkg::*;

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int PW   = CW + 3;
	localparam int MAXR = (MAX_TAPS - 1) / 2;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                st_q;
	logic [RADIUS_W-1:0]   tap_q;
	logic [REG_W-1:0]      coef_q [COEF_WORDS];
	logic [CW-1:0]         count_q;
	logic                  dropped_q;
	logic [AW-1:0]         j_q;
	logic [TAP_W-1:0]      k_q;
	logic [RADIUS_W-1:0]   r_q;
	logic [RADIUS_W-1:0]   r_eff;
	logic                  vld_s1;
	coef_t                 coef_s1;
	coef_t                 coef_sel;
	logic [REG_W-1:0]      coef_word;
	logic                  in_acc;
	logic                  store_ok;
	logic                  last_tap;
	logic                  last_out;
	logic                  ld_out;
	logic                  issue;
	logic [AW-1:0]         rd_idx;
	logic signed [PW-1:0]  pos;
	logic signed [PW-1:0]  n_s;
	logic [SAMPLE_W-1:0]   rd_data;
	mac_ctl_t              mac_ctl;
	logic                  mac_busy;
	sample_t               mac_res;
	logic                  out_vld_q;
	sample_t               out_filtered_q;
	logic                  out_run_end_q;
	logic                  out_overflow_q;

	assign in_ch.ready = (st_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign store_ok    = (count_q < CW'(MAX_SAMPLES));
	assign issue       = (st_q == ST_RUN);
	assign last_tap    = (k_q == {r_q, 1'b0});
	assign last_out    = (CW'(j_q) == count_q - CW'(1));
	assign ld_out      = (st_q == ST_DRAIN) && !vld_s1 && !mac_busy
		&& (!out_vld_q || out_ch.ready);

	always_comb begin
		if (tap_q == '0) begin
			r_eff = RADIUS_W'(1);
		end else if (tap_q > RADIUS_W'(MAXR)) begin
			r_eff = RADIUS_W'(MAXR);
		end else begin
			r_eff = tap_q;
		end
	end

	always_comb begin
		coef_word = coef_q[k_q[3:2]];
		coef_sel  = coef_word[16*k_q[1:0] +: COEF_W];
	end

	// The edge sample repeats; indexes still outside a short frame are clamped.
	always_comb begin
		n_s = $signed({{(PW-CW){1'b0}}, count_q});
		pos = $signed({{(PW-AW){1'b0}}, j_q}) + $signed({{(PW-TAP_W){1'b0}}, k_q})
			- $signed({{(PW-RADIUS_W){1'b0}}, r_q});
		if (pos < 0) begin
			pos = ~pos;
		end else if (pos >= n_s) begin
			pos = (n_s <<< 1) - PW'(1) - pos;
		end
		if (pos < 0) begin
			pos = '0;
		end
		if (pos > n_s - PW'(1)) begin
			pos = n_s - PW'(1);
		end
		rd_idx = pos[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= RADIUS_W'(1);
			for (int i = 0; i < COEF_WORDS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAP_RADIUS: tap_q     <= cfg_data[RADIUS_W-1:0];
				REG_COEF_A:     coef_q[0] <= cfg_data;
				REG_COEF_B:     coef_q[1] <= cfg_data;
				REG_COEF_C:     coef_q[2] <= cfg_data;
				REG_COEF_D:     coef_q[3] <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			j_q       <= '0;
			k_q       <= '0;
			r_q       <= RADIUS_W'(1);
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (ld_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (store_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (in_ch.frame_end) begin
							st_q <= ST_RUN;
							j_q  <= '0;
							k_q  <= '0;
							r_q  <= r_eff;
						end
					end
				end
				ST_RUN: begin
					if (last_tap) begin
						k_q  <= '0;
						st_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + TAP_W'(1);
					end
				end
				ST_DRAIN: begin
					if (ld_out) begin
						if (last_out) begin
							st_q      <= ST_IDLE;
							count_q   <= '0;
							dropped_q <= 1'b0;
						end else begin
							j_q  <= j_q + AW'(1);
							st_q <= ST_RUN;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			coef_s1 <= coef_sel;
		end
		if (ld_out) begin
			out_filtered_q <= mac_res;
			out_run_end_q  <= last_out;
			out_overflow_q <= dropped_q;
		end
	end

	mfc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_frame_store (
		.clk   (clk),
		.we    (in_acc && store_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (in_ch.sample_in),
		.re    (issue),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	assign mac_ctl.tap_vld = vld_s1;
	assign mac_ctl.acc_clr = ld_out;

	mfc_mac #(
		.MAX_TAPS (MAX_TAPS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample ($signed(rd_data)),
		.coef   (coef_s1),
		.busy   (mac_busy),
		.result (mac_res)
	);

	assign out_ch.valid    = out_vld_q;
	assign out_ch.filtered = out_filtered_q;
	assign out_ch.run_end  = out_run_end_q;
	assign out_ch.overflow = out_overflow_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("Frame count exceeds the frame store depth.");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> (count_q == CW'(MAX_SAMPLES)))
		else $error("Overflow flag set while the frame store is not full.");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (k_q <= {r_q, 1'b0}))
		else $error("Tap counter ran past the kernel width.");

	a_radius_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> ((r_q >= RADIUS_W'(1)) && (r_q <= RADIUS_W'(MAXR))))
		else $error("Kernel radius out of range during a filter pass.");

	a_pass_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> (count_q != '0))
		else $error("Filter pass running on an empty frame.");
`endif

endmodule

// ===== tb/mirrored_fir_convolver_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirrored_fir_convolver_top_tb
// Self-checking bench for the mirrored-edge FIR convolver. Frames of sample
// words are sent under random handshake pressure and register settings. Each
// filtered word is compared against an in-bench filter of the same frame.
// ----------------------------------------------------------------------------
module mirrored_fir_convolver_top_tb;
	import mfc_pkg::*;

	localparam int FRAME_CAP    = MAX_SAMPLES_DEF;
	localparam int MAX_RADIUS   = (MAX_TAPS_DEF - 1) / 2;
	localparam int DRAIN_CYCLES = 2 * MAX_RADIUS + 12;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		sample_t filtered;
		logic    run_end;
		logic    overflow;
	} filtered_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;

	mfc_in_if  in_ch ();
	mfc_out_if out_ch ();

	mirrored_fir_convolver_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Filter state kept alongside the block.
	logic [RADIUS_W-1:0] radius_cfg;
	logic [REG_W-1:0]    coef_cfg [COEF_WORDS];
	sample_t             frame_buf [FRAME_CAP];
	int                  frame_len;
	logic                frame_dropped;

	filtered_word_t expected_words [$];
	filtered_word_t want_word;
	int             errors;
	int             cycle_count;
	int             tx_idle_pct;
	int             rx_idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word filtered %0d run_end %0b overflow %0b",
					$time, out_ch.filtered, out_ch.run_end, out_ch.overflow);
				errors++;
			end else begin
				want_word = expected_words.pop_front();
				if (out_ch.filtered !== want_word.filtered) begin
					$display("%0t: filtered expected %0d actual %0d", $time,
						want_word.filtered, out_ch.filtered);
					errors++;
				end
				if (out_ch.run_end !== want_word.run_end) begin
					$display("%0t: run_end expected %0b actual %0b", $time,
						want_word.run_end, out_ch.run_end);
					errors++;
				end
				if (out_ch.overflow !== want_word.overflow) begin
					$display("%0t: overflow expected %0b actual %0b", $time,
						want_word.overflow, out_ch.overflow);
					errors++;
				end
			end
		end
	end

	function automatic void filter_word(input sample_t s, input logic fe);
		int             r;
		int             n;
		int             p;
		int             j;
		int             k;
		coef_t          c;
		longint         acc;
		longint         q;
		filtered_word_t w;
		if (frame_len < FRAME_CAP) begin
			frame_buf[frame_len] = s;
			frame_len++;
		end else begin
			frame_dropped = 1'b1;
		end
		if (fe !== 1'b1)
			return;
		r = radius_cfg;
		if (r == 0)
			r = 1;
		if (r > MAX_RADIUS)
			r = MAX_RADIUS;
		n = frame_len;
		for (j = 0; j < n; j++) begin
			acc = 0;
			for (k = 0; k <= 2 * r; k++) begin
				p = j + k - r;
				if (p < 0)
					p = -p - 1;
				else if (p >= n)
					p = 2 * n - 1 - p;
				if (p < 0)
					p = 0;
				if (p > n - 1)
					p = n - 1;
				c = coef_cfg[k >> 2][(k & 3) * COEF_W +: COEF_W];
				acc += longint'(frame_buf[p]) * longint'(c);
			end
			q = (acc + 16384) >>> 15;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			w.filtered = sample_t'(q);
			w.run_end  = (j == n - 1);
			w.overflow = frame_dropped;
			expected_words.push_back(w);
		end
		frame_len     = 0;
		frame_dropped = 1'b0;
	endfunction

	function automatic logic [REG_W-1:0] rand_coef_word(input bit full_range);
		logic [REG_W-1:0] word;
		int               i;
		word = {$urandom, $urandom};
		if (!full_range) begin
			for (i = 0; i < 4; i++)
				word[i * COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 8191) - 4096);
		end
		return word;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_word(input sample_t s, input logic fe);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		in_ch.frame_end <= fe;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		filter_word(s, fe);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [RADIUS_W-1:0] radius, input logic [REG_W-1:0] ca,
		input logic [REG_W-1:0] cb, input logic [REG_W-1:0] cc, input logic [REG_W-1:0] cd,
		input bit stray);
		logic [REG_W-1:0] words [COEF_WORDS];
		logic [REG_W-1:0] data;
		int               i;
		int               u;
		words[0] = ca;
		words[1] = cb;
		words[2] = cc;
		words[3] = cd;
		data = {$urandom, $urandom};
		data[RADIUS_W-1:0] = radius;
		cfg_we    <= 1'b1;
		cfg_index <= REG_TAP_RADIUS;
		cfg_data  <= data;
		@(posedge clk);
		radius_cfg = radius;
		for (i = 0; i < COEF_WORDS; i++) begin
			cfg_index <= REG_COEF_A + CFG_IDX_W'(i);
			cfg_data  <= words[i];
			@(posedge clk);
			coef_cfg[i] = words[i];
		end
		if (stray) begin
			for (u = REG_COEF_D + 1; u < (1 << CFG_IDX_W); u++) begin
				cfg_index <= CFG_IDX_W'(u);
				cfg_data  <= {$urandom, $urandom};
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_word(rand_sample(), i == len - 1);
	endtask

	task automatic test_reset_state();
		send_word(16'sd5, 1'b0);
		send_word(-16'sd7, 1'b0);
		send_word(16'sd12345, 1'b1);
	endtask

	task automatic test_edge_values();
		wait_idle();
		load_config(3'd1, {16'h0000, 16'h8000, 16'h7FFF, 16'h4000}, '0, '0, '0, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh0000, 1'b0);
		send_word(16'shFFFF, 1'b0);
		send_word(16'sh0001, 1'b1);
	endtask

	task automatic test_saturation();
		wait_idle();
		load_config(3'd7, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh7FFF, 1'b1);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh8000, 1'b1);
	endtask

	task automatic test_rounding();
		wait_idle();
		load_config(3'd1, {16'h0000, 16'h0000, 16'h0001, 16'h0000}, '1, '1, '1, 1'b0);
		send_word(16'sd16384, 1'b0);
		send_word(-16'sd16384, 1'b0);
		send_word(16'sd16383, 1'b0);
		send_word(-16'sd16385, 1'b1);
	endtask

	task automatic test_radius_zero();
		wait_idle();
		load_config(3'd0, rand_coef_word(1'b1), rand_coef_word(1'b1), rand_coef_word(1'b1),
			rand_coef_word(1'b1), 1'b1);
		send_frame(4);
	endtask

	task automatic test_short_frame();
		wait_idle();
		load_config(3'd7, rand_coef_word(1'b0), rand_coef_word(1'b0), rand_coef_word(1'b0),
			rand_coef_word(1'b0), 1'b0);
		send_frame(1);
		send_frame(2);
	endtask

	task automatic test_frame_overflow();
		wait_idle();
		load_config(RADIUS_W'($urandom_range(1, MAX_RADIUS)), rand_coef_word(1'b0),
			rand_coef_word(1'b0), rand_coef_word(1'b0), rand_coef_word(1'b0), 1'b0);
		send_frame(FRAME_CAP + 6);
		send_frame(FRAME_CAP);
		send_frame(FRAME_CAP + 1);
	endtask

	task automatic test_random_frames(input int tx_pct, input int rx_pct, input int n_words);
		int sent;
		int len;
		int pick;
		bit full_range;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				full_range = $urandom_range(0, 1);
				load_config(RADIUS_W'($urandom), rand_coef_word(full_range),
					rand_coef_word(full_range), rand_coef_word(full_range),
					rand_coef_word(full_range), $urandom_range(0, 1));
			end else if ($urandom_range(0, 15) == 0) begin
				wait_idle();
			end
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = $urandom_range(FRAME_CAP - 2, FRAME_CAP + 6);
			else if (pick < 4)
				len = $urandom_range(13, FRAME_CAP);
			else
				len = $urandom_range(1, 12);
			send_frame(len);
			sent += len;
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_TAP_RADIUS;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		in_ch.frame_end = 1'b0;
		errors          = 0;
		cycle_count     = 0;
		tx_idle_pct     = 18;
		rx_idle_pct     = 72;
		radius_cfg      = 3'd1;
		coef_cfg        = '{default: '0};
		frame_len       = 0;
		frame_dropped   = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_edge_values();
		test_saturation();
		test_rounding();
		test_radius_zero();
		test_short_frame();
		test_frame_overflow();
		test_random_frames(18, 72, 55);
		test_random_frames(72, 18, 55);
		test_random_frames(0, 0, 55);

		wait_idle();
		if (errors == 0 && expected_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
